@@ rtl/cd_sector_mapper_top_macros.svh @@
// ----------------------------------------------------------------------------
// cd sector mapper assertion macros
// shared concurrent assertion forms, clocked on clk, off during reset
// ----------------------------------------------------------------------------
`ifndef CD_SECTOR_MAPPER_TOP_MACROS_SVH
`define CD_SECTOR_MAPPER_TOP_MACROS_SVH

// condition in this cycle implies a property in the same cycle
`define CDSM_ASSERT_IMPL(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error(msg);

// condition in this cycle implies a property in the next cycle
`define CDSM_ASSERT_NEXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);

`endif

@@ rtl/cdsm_pkg.sv @@
// ----------------------------------------------------------------------------
// cdsm_pkg
// types, constants and helpers shared by the cd sector mapper modules
// ----------------------------------------------------------------------------
package cdsm_pkg;

  // field widths
  localparam int SEC_W     = 19;
  localparam int BOFF_W    = 12;
  localparam int TIDX_W    = 7;
  localparam int OFF_W     = 31;
  localparam int BYTE_W    = 8;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DAT_W = 8;

  // default sizing
  localparam int MAX_TRACKS_DEF       = 128;
  localparam int RAW_SECTOR_BYTES_DEF = 2352;

  // sector layout constants
  localparam int ISO_SHIFT      = 11;    // 2048-byte iso sectors
  localparam int PREGAP_SECTORS = 150;
  localparam int HEADER_BYTES   = 16;
  localparam int SYNC_LAST      = 11;
  localparam int ISO_DATA_LAST  = 2064;  // header plus iso payload
  localparam int FRAMES_PER_SEC = 75;
  localparam int SECS_PER_MIN   = 60;

  // reciprocal constants for the msf split
  localparam int                RECIP75_W = 26;
  localparam logic [RECIP75_W-1:0] RECIP75 = 26'd57266231;  // ceil(2^32/75)
  localparam int                SHIFT75   = 32;
  localparam int                RECIP60_W = 21;
  localparam logic [RECIP60_W-1:0] RECIP60 = 21'd1118482;   // ceil(2^26/60)
  localparam int                SHIFT60   = 26;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_FORMAT = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRACK_COUNT  = 4'd1;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_SEEK = 2'd1,
    OP_READ = 2'd2,
    OP_NOP  = 2'd3
  } opcode_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SIMPLE,
    S_READ,
    S_MSF_A,
    S_MSF_B,
    S_MSF_C,
    S_WALK_RD,
    S_WALK_EV,
    S_BIN_OFF,
    S_ISO_OFF,
    S_DONE
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic latch;
    logic simple;
    logic read;
    logic msf_a;
    logic msf_b;
    logic msf_c;
    logic walk_rd;
    logic walk_ev;
    logic bin_off;
    logic iso_off;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic iso;
    logic n_zero;
    logic walk_hit;
    logic walk_last;
  } stat_t;

  // two-digit bcd of a value below 128, low 8 bits kept
  function automatic logic [7:0] to_bcd(input logic [6:0] v);
    logic [14:0] p;
    logic [3:0]  tens;
    logic [6:0]  ones;
    p    = 15'(v) * 15'd205;
    tens = p[14:11];
    ones = v - 7'(tens) * 7'd10;
    return {tens, ones[3:0]};
  endfunction

endpackage

@@ rtl/cdsm_ctrl.sv @@
// ----------------------------------------------------------------------------
// cdsm_ctrl
// sequencer for load, seek, read: issues datapath commands, drives busy/strobe
// ----------------------------------------------------------------------------
`include "cd_sector_mapper_top_macros.svh"

module cdsm_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [1:0]         opcode,
  input  cdsm_pkg::stat_t    stat,
  output logic               busy,
  output logic               out_valid,
  output cdsm_pkg::cmd_t     cmd
);
  import cdsm_pkg::*;

  state_t state_r, state_nxt;
  logic   accept;

  assign busy      = !(state_r == S_IDLE || state_r == S_DONE);
  assign out_valid = (state_r == S_DONE);
  assign accept    = start && !busy;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.latch = accept;
    unique case (state_r)
      S_IDLE, S_DONE: begin
        if (accept) begin
          case (opcode_t'(opcode))
            OP_SEEK: state_nxt = S_MSF_A;
            OP_READ: state_nxt = S_READ;
            default: state_nxt = S_SIMPLE;
          endcase
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_SIMPLE: begin
        cmd.simple = 1'b1;
        state_nxt  = S_DONE;
      end
      S_READ: begin
        cmd.read  = 1'b1;
        state_nxt = S_DONE;
      end
      S_MSF_A: begin
        cmd.msf_a = 1'b1;
        state_nxt = S_MSF_B;
      end
      S_MSF_B: begin
        cmd.msf_b = 1'b1;
        state_nxt = S_MSF_C;
      end
      S_MSF_C: begin
        cmd.msf_c = 1'b1;
        if (stat.iso) begin
          state_nxt = S_ISO_OFF;
        end else if (stat.n_zero) begin
          state_nxt = S_BIN_OFF;
        end else begin
          state_nxt = S_WALK_RD;
        end
      end
      S_WALK_RD: begin
        cmd.walk_rd = 1'b1;
        state_nxt   = S_WALK_EV;
      end
      S_WALK_EV: begin
        cmd.walk_ev = 1'b1;
        if (stat.walk_hit || stat.walk_last) begin
          state_nxt = S_BIN_OFF;
        end else begin
          state_nxt = S_WALK_RD;
        end
      end
      S_BIN_OFF: begin
        cmd.bin_off = 1'b1;
        state_nxt   = S_DONE;
      end
      S_ISO_OFF: begin
        cmd.iso_off = 1'b1;
        state_nxt   = S_DONE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // checks
  `CDSM_ASSERT_NEXT(a_strobe_single, state_r == S_DONE, state_r != S_DONE, "result strobe repeated")
  `CDSM_ASSERT_NEXT(a_accept_busy, accept, busy, "not busy after accepting an item")
  `CDSM_ASSERT_NEXT(a_walk_pair, cmd.walk_rd, state_r == S_WALK_EV, "table read not evaluated")

endmodule

@@ rtl/cdsm_datapath.sv @@
// ----------------------------------------------------------------------------
// cdsm_datapath
// config registers, track table memory, walk unit, msf split, result registers
// ----------------------------------------------------------------------------
`include "cd_sector_mapper_top_macros.svh"

module cdsm_datapath #(
  parameter int MAX_TRACKS       = cdsm_pkg::MAX_TRACKS_DEF,
  parameter int RAW_SECTOR_BYTES = cdsm_pkg::RAW_SECTOR_BYTES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  cdsm_pkg::cmd_t                    cmd,
  output cdsm_pkg::stat_t                   stat,
  input  logic                              cfg_wr,
  input  logic [cdsm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [cdsm_pkg::CFG_DAT_W-1:0]    cfg_data,
  input  logic [cdsm_pkg::SEC_W-1:0]        in_sector,
  input  logic [cdsm_pkg::BOFF_W-1:0]       in_byte_offset,
  input  logic [cdsm_pkg::TIDX_W-1:0]       in_track_index,
  input  logic [cdsm_pkg::SEC_W-1:0]        in_pregap_len,
  input  logic [cdsm_pkg::SEC_W-1:0]        in_track_start,
  input  logic [cdsm_pkg::SEC_W-1:0]        in_track_end,
  input  logic [1:0]                        in_opcode,
  output logic                              out_in_pregap,
  output logic                              out_offset_valid,
  output logic [cdsm_pkg::OFF_W-1:0]        out_file_offset,
  output logic                              out_from_file,
  output logic [cdsm_pkg::BYTE_W-1:0]       out_data_byte
);
  import cdsm_pkg::*;

  localparam int AW    = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
  localparam int CNT_W = $clog2(MAX_TRACKS + 1);
  localparam int P75_W = SEC_W + RECIP75_W;
  localparam int Q75_W = P75_W - SHIFT75;
  localparam int P60_W = Q75_W + RECIP60_W;

  typedef struct packed {
    logic [SEC_W-1:0] pregap;
    logic [SEC_W-1:0] first;
    logic [SEC_W-1:0] last;
  } entry_t;

  // configuration
  logic             iso_r;
  logic [7:0]       track_count_r;

  // latched item
  logic [1:0]        op_r;
  logic [SEC_W-1:0]  sector_r;
  logic [BOFF_W-1:0] boff_r;
  logic [TIDX_W-1:0] tidx_r;
  entry_t            load_r;

  // track table
  entry_t mem [MAX_TRACKS];
  entry_t rd_r;

  // walk state
  logic [SEC_W-1:0] lba_r;
  logic [CNT_W-1:0] idx_r;
  logic [CNT_W-1:0] n_r;
  logic             flag_r;

  // msf split and current-sector header bytes
  logic [P75_W-1:0] p75_r;
  logic [Q75_W-1:0] q75_r;
  logic [P60_W-1:0] p60_r;
  logic [6:0]       frames_r;
  logic [7:0]       bcd_min_r, bcd_sec_r, bcd_frm_r;

  // result registers
  logic              res_pregap_r;
  logic              res_valid_r;
  logic [OFF_W-1:0]  res_offset_r;
  logic              res_from_file_r;
  logic [BYTE_W-1:0] res_byte_r;

  // combinational helpers
  logic [Q75_W-1:0] q75;
  logic [6:0]       mins;
  logic [6:0]       secs;
  logic [SEC_W-1:0] lba_sub;
  logic             hit_pregap, hit_lead, hit_track;
  logic             synth;
  logic [7:0]       hdr_byte;
  logic [SEC_W-1:0] iso_lba;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iso_r         <= 1'b0;
      track_count_r <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        CFG_IMAGE_FORMAT: iso_r         <= cfg_data[0];
        CFG_TRACK_COUNT:  track_count_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r          <= in_opcode;
      sector_r      <= in_sector;
      boff_r        <= in_byte_offset;
      tidx_r        <= in_track_index;
      load_r.pregap <= in_pregap_len;
      load_r.first  <= in_track_start;
      load_r.last   <= in_track_end;
    end
  end

  // track table write and registered read
  always_ff @(posedge clk) begin
    if (cmd.simple && opcode_t'(op_r) == OP_LOAD && 8'(tidx_r) < 8'(MAX_TRACKS)) begin
      mem[tidx_r[AW-1:0]] <= load_r;
    end
    if (cmd.walk_rd) begin
      rd_r <= mem[idx_r[AW-1:0]];
    end
  end

  // walk step evaluation
  assign lba_sub    = lba_r - rd_r.pregap;
  assign hit_pregap = lba_r < rd_r.pregap;
  assign hit_lead   = lba_sub < rd_r.first;
  assign hit_track  = lba_sub < rd_r.last;

  assign stat.iso       = iso_r;
  assign stat.n_zero    = (n_r == '0);
  assign stat.walk_hit  = hit_pregap || hit_lead || hit_track;
  assign stat.walk_last = ({1'b0, idx_r} + 1'b1) == {1'b0, n_r};

  // msf split helpers
  assign q75  = p75_r[P75_W-1:SHIFT75];
  assign mins = p60_r[SHIFT60+6:SHIFT60];
  assign secs = 7'(q75_r - Q75_W'(mins) * Q75_W'(SECS_PER_MIN));

  // seek control state and msf split
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flag_r    <= 1'b0;
      bcd_min_r <= '0;
      bcd_sec_r <= '0;
      bcd_frm_r <= '0;
    end else begin
      if (cmd.msf_c) begin
        bcd_min_r <= to_bcd(mins);
        bcd_sec_r <= to_bcd(secs);
        bcd_frm_r <= to_bcd(frames_r);
      end
      if (cmd.walk_ev) begin
        if (hit_pregap || hit_lead) begin
          flag_r <= 1'b1;
        end else if (hit_track) begin
          flag_r <= 1'b0;
        end
      end
      if (cmd.iso_off) begin
        flag_r <= (sector_r < SEC_W'(PREGAP_SECTORS));
      end
    end
  end

  // walk counters and products
  always_ff @(posedge clk) begin
    if (cmd.msf_a) begin
      p75_r <= P75_W'(sector_r) * P75_W'(RECIP75);
      lba_r <= sector_r;
      idx_r <= '0;
      n_r   <= (track_count_r > 8'(MAX_TRACKS)) ? CNT_W'(MAX_TRACKS)
                                                  : track_count_r[CNT_W-1:0];
    end
    if (cmd.msf_b) begin
      q75_r    <= q75;
      frames_r <= 7'(sector_r - SEC_W'(q75) * SEC_W'(FRAMES_PER_SEC));
      p60_r    <= P60_W'(q75) * P60_W'(RECIP60);
    end
    if (cmd.walk_ev) begin
      if (!hit_pregap) begin
        lba_r <= lba_sub;
      end
      idx_r <= idx_r + 1'b1;
    end
  end

  // synthesized header byte of the current sector
  always_comb begin
    if (boff_r == '0 || boff_r >= BOFF_W'(HEADER_BYTES)) begin
      hdr_byte = 8'h00;
    end else if (boff_r <= BOFF_W'(SYNC_LAST)) begin
      hdr_byte = 8'hFF;
    end else if (boff_r == BOFF_W'(SYNC_LAST + 1)) begin
      hdr_byte = bcd_min_r;
    end else if (boff_r == BOFF_W'(SYNC_LAST + 2)) begin
      hdr_byte = bcd_sec_r;
    end else if (boff_r == BOFF_W'(SYNC_LAST + 3)) begin
      hdr_byte = bcd_frm_r;
    end else begin
      hdr_byte = 8'h01;
    end
  end

  assign synth = flag_r || (iso_r && (boff_r < BOFF_W'(HEADER_BYTES) ||
                                      boff_r > BOFF_W'(ISO_DATA_LAST)));
  assign iso_lba = sector_r - SEC_W'(PREGAP_SECTORS);

  // result registers
  always_ff @(posedge clk) begin
    if (cmd.simple) begin
      res_pregap_r    <= flag_r;
      res_valid_r     <= 1'b0;
      res_offset_r    <= '0;
      res_from_file_r <= 1'b0;
      res_byte_r      <= '0;
    end
    if (cmd.read) begin
      res_pregap_r    <= flag_r;
      res_valid_r     <= 1'b0;
      res_offset_r    <= '0;
      res_from_file_r <= !synth;
      res_byte_r      <= synth ? hdr_byte : 8'h00;
    end
    if (cmd.bin_off) begin
      res_pregap_r    <= flag_r;
      res_valid_r     <= !flag_r;
      res_offset_r    <= flag_r ? '0 : OFF_W'(OFF_W'(lba_r) * OFF_W'(RAW_SECTOR_BYTES));
      res_from_file_r <= 1'b0;
      res_byte_r      <= '0;
    end
    if (cmd.iso_off) begin
      res_from_file_r <= 1'b0;
      res_byte_r      <= '0;
      if (sector_r < SEC_W'(PREGAP_SECTORS)) begin
        res_pregap_r <= 1'b1;
        res_valid_r  <= 1'b0;
        res_offset_r <= '0;
      end else begin
        res_pregap_r <= 1'b0;
        res_valid_r  <= 1'b1;
        res_offset_r <= OFF_W'({iso_lba, {ISO_SHIFT{1'b0}}});
      end
    end
  end

  assign out_in_pregap    = res_pregap_r;
  assign out_offset_valid = res_valid_r;
  assign out_file_offset  = res_offset_r;
  assign out_from_file    = res_from_file_r;
  assign out_data_byte    = res_byte_r;

  // checks
  `CDSM_ASSERT_IMPL(a_walk_in_range, cmd.walk_ev, idx_r < n_r, "walk past track count")
  `CDSM_ASSERT_NEXT(a_walk_reset, cmd.msf_a, idx_r == '0, "walk index not cleared")
  `CDSM_ASSERT_NEXT(a_iso_pregap, cmd.iso_off && sector_r < SEC_W'(PREGAP_SECTORS), flag_r, "iso pregap not flagged")

endmodule

@@ rtl/cd_sector_mapper_top.sv @@
// ----------------------------------------------------------------------------
// cd_sector_mapper_top
// cd sector to image offset mapper with pregap header byte synthesis
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; its single result is
// shown for exactly one cycle with out_valid and must be taken then, the
// receiver cannot hold it off. Busy drops in the result cycle, so the next
// item can be taken while the previous result is shown. A seek runs the msf
// split; an iso seek then forms its offset, while a bin seek first walks the
// track entries until a hit (at most the lesser of track_count and MAX_TRACKS
// entries), each read from the track table memory through its single
// registered read port and then evaluated, one entry at a time.
// Configuration writes are always ready; they must be made only while idle.
// ----------------------------------------------------------------------------
module cd_sector_mapper_top #(
  parameter int MAX_TRACKS       = cdsm_pkg::MAX_TRACKS_DEF,
  parameter int RAW_SECTOR_BYTES = cdsm_pkg::RAW_SECTOR_BYTES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        in_opcode,
  input  logic [cdsm_pkg::SEC_W-1:0]        in_sector,
  input  logic [cdsm_pkg::BOFF_W-1:0]       in_byte_offset,
  input  logic [cdsm_pkg::TIDX_W-1:0]       in_track_index,
  input  logic [cdsm_pkg::SEC_W-1:0]        in_pregap_len,
  input  logic [cdsm_pkg::SEC_W-1:0]        in_track_start,
  input  logic [cdsm_pkg::SEC_W-1:0]        in_track_end,
  output logic                              out_valid,
  output logic                              out_in_pregap,
  output logic                              out_offset_valid,
  output logic [cdsm_pkg::OFF_W-1:0]        out_file_offset,
  output logic                              out_from_file,
  output logic [cdsm_pkg::BYTE_W-1:0]       out_data_byte,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [cdsm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [cdsm_pkg::CFG_DAT_W-1:0]    cfg_data
);
  import cdsm_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  // sequencer
  cdsm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .opcode    (in_opcode),
    .stat      (stat),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  // datapath
  cdsm_datapath #(
    .MAX_TRACKS       (MAX_TRACKS),
    .RAW_SECTOR_BYTES (RAW_SECTOR_BYTES)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .cfg_wr           (cfg_valid && cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_sector        (in_sector),
    .in_byte_offset   (in_byte_offset),
    .in_track_index   (in_track_index),
    .in_pregap_len    (in_pregap_len),
    .in_track_start   (in_track_start),
    .in_track_end     (in_track_end),
    .in_opcode        (in_opcode),
    .out_in_pregap    (out_in_pregap),
    .out_offset_valid (out_offset_valid),
    .out_file_offset  (out_file_offset),
    .out_from_file    (out_from_file),
    .out_data_byte    (out_data_byte)
  );

endmodule
